// File: design/ffha_pkg.sv
package ffha_pkg;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ZERO   = 3'd1,
    ST_OOM    = 3'd2,
    ST_ALIGN  = 3'd3,
    ST_RANGE  = 3'd4,
    ST_DOUBLE = 3'd5
  } status_e;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic          mode;
    logic [15:0]   request_bytes;
    logic [15:0]   free_offset;
  } req_t;

  typedef struct packed {
    status_e       status;
    logic [15:0]   result_offset;
    logic [15:0]   bytes_in_use;
    logic [15:0]   bytes_avail;
  } rsp_t;

endpackage

// File: design/ffha_if.sv
interface ffha_req_if;
  logic               valid;
  logic               ready;
  ffha_pkg::req_t     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ffha_rsp_if;
  logic               valid;
  logic               ready;
  ffha_pkg::rsp_t     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/ffha_hdr_mem.sv
module ffha_hdr_mem #(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [(2**AW)-1:0];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: design/first_fit_heap_allocator_core.sv
// Channel  | Dir | Payload
// req      | in  | mode, request_bytes, free_offset
// rsp      | out | status, result_offset, bytes_in_use, bytes_avail
//
// Every header read on a walk or a merge passes an address state (S_RD or S_MRD), then the
// registered read of the header memory (S_CHK or S_MCHK). A request rejected on its fields
// goes straight to S_DONE; the longest request is a walk over a full arena of tiny blocks.
// Reset is asynchronous; the header of granule 0 is taken from a reset flag
// until it is first written, so no clearing pass is needed.
// A request is accepted whenever the engine is idle; a response waiting in the output
// register stalls only the S_DONE state of the next request until it is taken.
module first_fit_heap_allocator_core #(
  parameter int unsigned ARENA_BYTES = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffha_req_if.sink   req,
  ffha_rsp_if.source rsp
);

  localparam int unsigned Granules = ARENA_BYTES / 16;
  localparam int unsigned AW = $clog2(Granules);
  localparam int unsigned SW = AW + 1;   // walk index may reach Granules
  localparam int unsigned DW = AW + 1;   // size plus used mark
  localparam int unsigned TW = AW + 5;   // byte totals
  localparam int unsigned NW = (SW > 13) ? SW : 13;   // granules asked for

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_CHK   = 7'b0000100,
    S_SPLIT = 7'b0001000,
    S_MRD   = 7'b0010000,
    S_MCHK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic                mode_q, mode_d;
  logic [NW-1:0]       need_q, need_d;
  logic [SW-1:0]       g_q, g_d;
  logic [SW-1:0]       tgt_q, tgt_d;
  logic [SW-1:0]       s_q, s_d;
  logic [TW-1:0]       used_q, used_d;
  logic [SW-1:0]       cnt_q, cnt_d;
  logic                h0_q, h0_d;
  ffha_pkg::status_e   st_q, st_d;
  logic [15:0]         off_q, off_d;
  logic                ov_q, ov_d;
  ffha_pkg::rsp_t      rsp_q, rsp_d;
  // Marks a free request that found its live block and must write it back.
  logic                fr_valid_q, fr_valid_d;

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [DW-1:0]       wdata, rdata, hdr;
  logic [SW-1:0]       hsz;
  logic                hused;
  logic [SW-1:0]       nxt;

  ffha_hdr_mem #(.AW(AW), .DW(DW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign raddr = g_q[AW-1:0];
  // Granule 0 reads as the whole-arena free block until first written.
  assign hdr   = (h0_q && g_q == '0) ? {AW'(Granules - 1), 1'b0} : rdata;
  assign hsz   = {1'b0, hdr[DW-1:1]};
  assign hused = hdr[0];
  assign nxt   = g_q + SW'(1) + hsz;

  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = ov_q;
  assign rsp.data  = rsp_q;

  always_comb begin
    logic [16:0] rb;
    logic [SW-1:0] left;
    logic [TW-1:0] fb;
    state_d = state_q; mode_d = mode_q; need_d = need_q; g_d = g_q; tgt_d = tgt_q;
    s_d = s_q; used_d = used_q; cnt_d = cnt_q; h0_d = h0_q; st_d = st_q;
    off_d = off_q; ov_d = ov_q; rsp_d = rsp_q;
    we = 1'b0; waddr = '0; wdata = '0;
    rb = 17'(req.data.request_bytes) + 17'd15;
    left = s_q - SW'(need_q);
    fb = '0;
    if (ov_q && rsp.ready) ov_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          mode_d = req.data.mode;
          g_d = '0;
          off_d = '0;
          st_d = ffha_pkg::ST_OK;
          need_d = NW'(rb[16:4]);
          tgt_d = SW'(req.data.free_offset[15:4]) - SW'(1);
          state_d = S_RD;
          if (req.data.mode == ffha_pkg::MODE_ALLOC) begin
            if (req.data.request_bytes == '0) begin
              st_d = ffha_pkg::ST_ZERO; state_d = S_DONE;
            end
          end else if (req.data.free_offset == '0) begin
            state_d = S_DONE;
          end else if (req.data.free_offset[3:0] != '0) begin
            st_d = ffha_pkg::ST_ALIGN; state_d = S_DONE;
          end else if (req.data.free_offset < 16'd16 ||
                       32'(req.data.free_offset) >= 32'(ARENA_BYTES)) begin
            st_d = ffha_pkg::ST_RANGE; state_d = S_DONE;
          end
        end
      end
      S_RD: begin
        if (g_q >= SW'(Granules) || (mode_q == ffha_pkg::MODE_FREE && g_q >= tgt_q)) begin
          if (mode_q == ffha_pkg::MODE_ALLOC) begin
            st_d = ffha_pkg::ST_OOM; state_d = S_DONE;
          end else if (g_q != tgt_q) begin
            st_d = ffha_pkg::ST_DOUBLE; state_d = S_DONE;
          end else begin
            state_d = S_CHK;
          end
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        s_d = hsz;
        if (mode_q == ffha_pkg::MODE_ALLOC) begin
          if (!hused && NW'(hsz) >= need_q) begin
            state_d = S_SPLIT;
          end else begin
            g_d = nxt; state_d = S_RD;
          end
        end else if (g_q < tgt_q) begin
          g_d = nxt; state_d = S_RD;
        end else if (!hused) begin
          st_d = ffha_pkg::ST_DOUBLE; state_d = S_DONE;
        end else begin
          used_d = used_q - TW'(hsz) * TW'(16);
          tgt_d = g_q;
          g_d = nxt;
          state_d = S_MRD;
        end
      end
      S_SPLIT: begin
        // Write the leftover header here; the granted header follows in S_DONE.
        if (left >= SW'(2)) begin
          we = 1'b1;
          waddr = AW'(g_q + SW'(1) + SW'(need_q));
          wdata = {AW'(left - SW'(1)), 1'b0};
          s_d = SW'(need_q);
          cnt_d = cnt_q + SW'(1);
        end
        off_d = 16'((32'(g_q) + 32'd1) * 32'd16);
        state_d = S_DONE;
      end
      S_MRD: begin
        if (g_q >= SW'(Granules)) state_d = S_DONE;
        else state_d = S_MCHK;
      end
      S_MCHK: begin
        if (!hused) begin
          s_d = s_q + SW'(1) + hsz;
          cnt_d = cnt_q - SW'(1);
          g_d = nxt;
          state_d = S_MRD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Wait here until the output register can take the response.
        if (!ov_q || rsp.ready) begin
          if (st_q == ffha_pkg::ST_OK && mode_q == ffha_pkg::MODE_ALLOC) begin
            we = 1'b1;
            waddr = AW'(g_q);
            wdata = {AW'(s_q), 1'b1};
            used_d = used_q + TW'(s_q) * TW'(16);
            if (g_q == '0) h0_d = 1'b0;
          end else if (st_q == ffha_pkg::ST_OK && mode_q == ffha_pkg::MODE_FREE
                       && fr_valid_q) begin
            we = 1'b1;
            waddr = AW'(tgt_q);
            wdata = {AW'(s_q), 1'b0};
            if (tgt_q == '0) h0_d = 1'b0;
          end
          fb = (TW'(Granules) - TW'(cnt_q)) * TW'(16) - used_d;
          rsp_d.status        = st_q;
          rsp_d.result_offset = off_q;
          rsp_d.bytes_in_use  = 16'(used_d);
          rsp_d.bytes_avail   = 16'(fb);
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    fr_valid_d = fr_valid_q;
    if (state_q == S_IDLE) fr_valid_d = 1'b0;
    else if (state_q == S_CHK && mode_q == ffha_pkg::MODE_FREE && g_q >= tgt_q && hused)
      fr_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0;
      used_q <= '0;
      cnt_q <= SW'(1);
      h0_q <= 1'b1;
      fr_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
      used_q <= used_d;
      cnt_q <= cnt_d;
      h0_q <= h0_d;
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; need_q <= need_d; g_q <= g_d; tgt_q <= tgt_d;
    s_q <= s_d; st_q <= st_d; off_q <= off_d; rsp_q <= rsp_d;
  end

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !rsp.ready) |=> $stable(rsp.data)) else $error("response changed while held");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !rsp.ready) |=> ov_q) else $error("result dropped");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0) else $error("block count zero");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> ov_q) else $error("result not raised");

endmodule
